>>> hw/rtl/nlf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nlf_pkg
// Shared types and character codes for the newline line framer.
// ----------------------------------------------------------------------------
package nlf_pkg;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam logic OP_BYTE     = 1'b0;
    localparam logic OP_OVERFLOW = 1'b1;

    localparam logic KIND_LINE  = 1'b0;
    localparam logic KIND_FAULT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic write_byte;
        logic clr_len;
        logic set_disc;
        logic clr_disc;
        logic rst_idx;
        logic rd_en;
        logic inc_idx;
        logic load_fault;
        logic load_line;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_overflow;
        logic is_lf;
        logic is_cr;
        logic discarding;
        logic len_zero;
        logic len_full;
        logic last_idx;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/nlf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nlf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/nlf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nlf_ctrl
// Controller: decodes each accepted item and sequences line readout.
// ----------------------------------------------------------------------------
module nlf_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire nlf_pkg::sts_t sts,
    output nlf_pkg::cmd_t      cmd
);

    import nlf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                priority if (sts.is_overflow || (!sts.discarding && !sts.is_cr &&
                                                 !sts.is_lf && sts.len_full))
                begin
                    // fault: needs the output slot
                    if (sts.out_free)
                    begin
                        cmd.load_fault = 1'b1;
                        cmd.clr_len    = 1'b1;
                        cmd.set_disc   = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (sts.discarding)
                begin
                    cmd.clr_disc = sts.is_lf;
                    state_next   = S_IDLE;
                end
                else if (sts.is_cr)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.is_lf)
                begin
                    if (sts.len_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rst_idx = 1'b1;
                        state_next  = S_RD;
                    end
                end
                else
                begin
                    cmd.write_byte = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_line = 1'b1;
                    cmd.inc_idx   = 1'b1;
                    if (sts.last_idx)
                    begin
                        cmd.clr_len = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/nlf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nlf_dp
// Datapath: input register, line store, length and index counters,
// discard flag and output register.
// ----------------------------------------------------------------------------
module nlf_dp #(
    parameter int LINE_BYTES = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_op,
    input  wire logic [7:0]    in_byte,
    input  wire nlf_pkg::cmd_t cmd,
    output nlf_pkg::sts_t      sts,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               out_kind,
    output logic [7:0]         out_byte,
    output logic               out_last
);

    import nlf_pkg::*;

    localparam int W = $clog2(LINE_BYTES);

    logic         op_reg;
    logic [7:0]   byte_reg;
    logic [W-1:0] len_reg;
    logic [W-1:0] len_next;
    logic [W-1:0] idx_reg;
    logic [W-1:0] idx_next;
    logic         disc_reg;
    logic         disc_next;
    logic         ovalid_reg;
    logic         ovalid_next;
    logic         okind_reg;
    logic [7:0]   obyte_reg;
    logic         olast_reg;
    logic [7:0]   rd_data;
    logic         last_idx;

    nlf_ram #(
        .WIDTH(8),
        .DEPTH(LINE_BYTES)
    ) u_store (
        .clk    (clk),
        .wr_en  (cmd.write_byte),
        .wr_addr(len_reg),
        .wr_data(byte_reg),
        .rd_en  (cmd.rd_en),
        .rd_addr(idx_reg),
        .rd_data(rd_data)
    );

    assign last_idx = (({1'b0, idx_reg} + {{W{1'b0}}, 1'b1}) == {1'b0, len_reg});

    always_comb
    begin
        sts.is_overflow = (op_reg == OP_OVERFLOW);
        sts.is_lf       = (byte_reg == CHAR_LF);
        sts.is_cr       = (byte_reg == CHAR_CR);
        sts.discarding  = disc_reg;
        sts.len_zero    = (len_reg == '0);
        sts.len_full    = (len_reg == W'(LINE_BYTES - 1));
        sts.last_idx    = last_idx;
        sts.out_free    = !ovalid_reg || out_ready;
    end

    always_comb
    begin
        len_next = len_reg;
        if (cmd.clr_len)
        begin
            len_next = '0;
        end
        else if (cmd.write_byte)
        begin
            len_next = len_reg + W'(1);
        end

        idx_next = idx_reg;
        if (cmd.rst_idx)
        begin
            idx_next = '0;
        end
        else if (cmd.inc_idx)
        begin
            idx_next = idx_reg + W'(1);
        end

        disc_next = disc_reg;
        if (cmd.set_disc)
        begin
            disc_next = 1'b1;
        end
        else if (cmd.clr_disc)
        begin
            disc_next = 1'b0;
        end

        ovalid_next = ovalid_reg;
        if (cmd.load_fault || cmd.load_line)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            idx_reg    <= '0;
            disc_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            len_reg    <= len_next;
            idx_reg    <= idx_next;
            disc_reg   <= disc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= in_op;
            byte_reg <= in_byte;
        end
        if (cmd.load_fault)
        begin
            okind_reg <= KIND_FAULT;
            obyte_reg <= 8'h00;
            olast_reg <= 1'b0;
        end
        else if (cmd.load_line)
        begin
            okind_reg <= KIND_LINE;
            obyte_reg <= rd_data;
            olast_reg <= last_idx;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_kind  = okind_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;

endmodule
`default_nettype wire

>>> hw/rtl/newline_line_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// newline_line_framer
// Splits received serial bytes into newline-terminated lines, drops carriage
// returns and reports line overflow or receive overflow as a fault.
// ----------------------------------------------------------------------------
// an item is accepted only when the previous item is done; a fault waits for a free output slot
// a fault result goes from the input register to the output register; output stalls delay it
// a line of n bytes is read out of the store one byte at a time, each byte a
// registered read of the single line store (read state, then output state), so
// the line feed holds the input until the last byte is loaded for output
// reset clears the controller, length, index, discard flag and output valid only
module newline_line_framer #(
    parameter int LINE_BYTES = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // rx_byte[7:0]
    input  wire logic       s_axis_tuser,   // op
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // line_byte[7:0]
    output logic            m_axis_tuser,   // kind
    output logic            m_axis_tlast
);

    import nlf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    nlf_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    nlf_dp #(
        .LINE_BYTES(LINE_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_op    (s_axis_tuser),
        .in_byte  (s_axis_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_kind (m_axis_tuser),
        .out_byte (m_axis_tdata),
        .out_last (m_axis_tlast)
    );

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the newline line framer. Directed tests cover short
// and empty lines, carriage returns, receive overflow events, discard until the
// next line feed and the full and over-long line limits. Random line traffic
// follows with bursty input, several receiver stall patterns and one long
// receiver hold-off. Every output transaction is compared with a prediction
// built from the accepted input transactions.
// ----------------------------------------------------------------------------
module tb_top;
    import nlf_pkg::*;

    localparam int LINE_BYTES   = 64;
    localparam int IDX_W        = $clog2(LINE_BYTES);
    localparam int RANDOM_ITEMS = 30;
    localparam int DRAIN_CYCLES = 2 * LINE_BYTES + 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 1500;

    typedef enum int {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PATTERN,
        RDY_SLOW
    } ready_mode_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } line_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // rx_byte[7:0]
    logic       s_axis_tuser = 1'b0;    // op
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // line_byte[7:0]
    logic       m_axis_tuser;           // kind
    logic       m_axis_tlast;

    line_result_t expected_line_q[$];
    logic [7:0]   line_copy [LINE_BYTES];
    int unsigned  line_fill = 0;
    bit           skip_to_lf = 1'b0;

    int          error_count = 0;
    int          cycle_count = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    ready_mode_t ready_mode = RDY_ALWAYS;
    int          hold_req = 0;
    int          hold_left = 0;
    int unsigned rx_phase = 0;
    logic [7:0]  ready_pattern = 8'b1011_0110;

    newline_line_framer #(
        .LINE_BYTES(LINE_BYTES)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_line_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // predicted framer behaviour for one accepted transaction
    task automatic frame_rx_item(input logic op, input logic [7:0] b);
        int unsigned i;
        if (op == OP_OVERFLOW || (!skip_to_lf && b != CHAR_CR && b != CHAR_LF
                                  && line_fill >= LINE_BYTES - 1))
        begin
            line_fill  = 0;
            skip_to_lf = 1'b1;
            expected_line_q.push_back('{KIND_FAULT, 8'h00, 1'b0});
        end
        else if (skip_to_lf)
        begin
            if (b == CHAR_LF)
                skip_to_lf = 1'b0;
        end
        else if (b == CHAR_LF)
        begin
            for (i = 0; i < line_fill; i++)
                expected_line_q.push_back('{KIND_LINE, line_copy[i[IDX_W-1:0]],
                                            i + 1 == line_fill});
            line_fill = 0;
        end
        else if (b != CHAR_CR)
        begin
            line_copy[line_fill[IDX_W-1:0]] = b;
            line_fill++;
        end
    endtask

    // sender: bursts of random length with random gaps in between
    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        frame_rx_item(op, b);
        items_sent++;
    endtask

    task automatic send_text_byte(input logic [7:0] b);
        send_item(OP_BYTE, b);
    endtask

    task automatic send_random_text(input int len);
        int i;
        logic [7:0] b;
        for (i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            while (b == CHAR_LF || b == CHAR_CR)
                b = 8'($urandom_range(0, 255));
            send_text_byte(b);
        end
    endtask

    // receiver stall patterns
    always @(posedge clk)
    begin
        rx_phase <= rx_phase + 1;
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            case (ready_mode)
                RDY_ALWAYS:  m_axis_tready <= 1'b1;
                RDY_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
                RDY_PATTERN: m_axis_tready <= ready_pattern[rx_phase[2:0]];
                default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // output checker
    always @(posedge clk)
    begin
        line_result_t got;
        line_result_t exp;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tuser, m_axis_tdata, m_axis_tlast};
            if (expected_line_q.size() == 0)
            begin
                $display("%0t: expected none, actual kind=%0d data=%02h last=%0d",
                         $time, got.kind, got.data, got.last);
                error_count++;
            end
            else
            begin
                exp = expected_line_q.pop_front();
                if (got.kind !== exp.kind || got.data !== exp.data
                    || got.last !== exp.last)
                begin
                    $display("%0t: mismatch expected %0d %02h %0d actual %0d %02h %0d",
                             $time, exp.kind, exp.data, exp.last,
                             got.kind, got.data, got.last);
                    error_count++;
                end
            end
        end
    end

    task automatic test_short_lines();
        ready_mode = RDY_ALWAYS;
        send_text_byte(8'h41);
        send_text_byte(8'h42);
        send_text_byte(CHAR_CR);
        send_text_byte(CHAR_LF);
        send_text_byte(CHAR_LF);
        send_text_byte(CHAR_CR);
        send_text_byte(CHAR_LF);
        send_text_byte(8'h00);
        send_text_byte(8'hFF);
        send_text_byte(CHAR_LF);
        send_text_byte(8'h7F);
        send_text_byte(CHAR_LF);
    endtask

    task automatic test_overflow_event();
        ready_mode = RDY_RANDOM;
        send_text_byte(8'h31);
        send_item(OP_OVERFLOW, 8'hA5);
        send_text_byte(8'h32);
        send_text_byte(CHAR_CR);
        send_item(OP_OVERFLOW, 8'h00);
        send_text_byte(CHAR_LF);
        send_text_byte(8'h33);
        send_text_byte(CHAR_LF);
        send_item(OP_OVERFLOW, CHAR_LF);
        send_text_byte(8'h34);
        send_text_byte(CHAR_LF);
        send_text_byte(CHAR_LF);
    endtask

    task automatic test_line_limits();
        ready_mode = RDY_PATTERN;
        send_random_text(LINE_BYTES - 1);
        send_text_byte(CHAR_CR);
        send_text_byte(CHAR_LF);
        // one byte too many gives a fault and discards to the line feed
        send_random_text(LINE_BYTES - 1);
        send_text_byte(8'h55);
        send_random_text(5);
        send_text_byte(CHAR_LF);
        send_random_text(3);
        send_text_byte(CHAR_LF);
    endtask

    task automatic test_backpressure();
        int n;
        ready_mode = RDY_RANDOM;
        gaps_on    = 1'b0;
        hold_req   = HOLD_CYCLES;
        send_random_text(24);
        send_text_byte(CHAR_LF);
        for (n = 0; n < 3; n++)
        begin
            send_random_text($urandom_range(1, 6));
            send_text_byte(CHAR_LF);
        end
        send_item(OP_OVERFLOW, 8'h5A);
        send_text_byte(CHAR_LF);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int start_count;
        int sel;
        int len;
        int i;
        logic op;
        logic [7:0] b;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                gaps_on    = 1'($urandom_range(0, 1));
            end
            sel = $urandom_range(0, 99);
            if (sel < 90)
            begin
                len = (sel < 80) ? $urandom_range(0, 12) : $urandom_range(40, 70);
                send_random_text(len);
                if ($urandom_range(0, 2) == 0)
                    send_text_byte(CHAR_CR);
                send_text_byte(CHAR_LF);
            end
            else
            begin
                // noise: raw bytes and stray overflow events
                len = $urandom_range(1, 10);
                for (i = 0; i < len; i++)
                begin
                    op = ($urandom_range(0, 4) == 0) ? OP_OVERFLOW : OP_BYTE;
                    b  = 8'($urandom_range(0, 255));
                    send_item(op, b);
                end
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_lines();
        test_overflow_event();
        test_line_limits();
        test_backpressure();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        while (expected_line_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_line_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/nlf_pkg.sv
hw/rtl/nlf_ram.sv
hw/rtl/nlf_ctrl.sv
hw/rtl/nlf_dp.sv
hw/rtl/newline_line_framer.sv
test/tb_top.sv
